### rtl/core/ptt_pkg.sv
// Package for the periodic timer table: field widths, command and result
// codes, and the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package ptt_pkg;

    localparam int MAX_TIMERS_DEF    = 16;
    localparam int INTERVAL_BITS_DEF = 16;

    localparam int CMD_W = 1;
    localparam int IVL_W = 16;
    localparam int ID_W  = 5;
    localparam int CFG_W = 5;

    localparam logic [CFG_W-1:0] MAX_TIMERS_RST = 5'd16;

    localparam logic [CMD_W-1:0] CMD_ADD  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_TICK = 1'b1;

    typedef enum logic [1:0] {
        KIND_ADDED   = 2'd0,
        KIND_REFUSED = 2'd1,
        KIND_EXPIRED = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_SCAN  = 2'd1,
        S_FLUSH = 2'd2
    } t_state;

endpackage

### rtl/core/ptt_if.sv
// Request and result channel interfaces of the periodic timer table.
// Depends on ptt_pkg for the field widths and the result kind type.
`timescale 1ns / 1ps

interface ptt_req_if import ptt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [IVL_W-1:0] interval;

    modport source (output valid, cmd, interval, input ready);
    modport sink   (input valid, cmd, interval, output ready);
endinterface

interface ptt_res_if import ptt_pkg::*; ();
    logic            valid;
    logic            ready;
    t_kind           kind;
    logic [ID_W-1:0] tmr_id;
    logic            last;

    modport source (output valid, kind, tmr_id, last, input ready);
    modport sink   (input valid, kind, tmr_id, last, output ready);
endinterface

### rtl/core/ptt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module ptt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/periodic_timer_table.sv
// Periodic timer table: an add request is handled as soon as it is accepted, and its result
// is valid the cycle after the request is accepted. A tick on an empty table gives no result.
// A tick walks the stored timers newest first, one RAM read per cycle while the result side
// does not stall, and no new request is taken until the scan and its last expiry result
// are through. Expiries leave one behind the scan for the last mark.
// Reset clears the count and sets the limit to 16; the table RAM is not cleared.
`timescale 1ns / 1ps

module periodic_timer_table import ptt_pkg::*; #(
    parameter int MAX_TIMERS    = MAX_TIMERS_DEF,
    parameter int INTERVAL_BITS = INTERVAL_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    ptt_req_if.sink          i_req,
    ptt_res_if.source        o_res
);

    localparam int IB = INTERVAL_BITS;
    localparam int CW = $clog2(MAX_TIMERS + 1);
    localparam int AW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int DW = 2 * IB;

    t_state          r_state, n_state;
    logic [CFG_W-1:0] r_max;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_rd_idx, n_rd_idx;
    logic [AW-1:0]   r_cur_idx, n_cur_idx;
    logic            r_rd_more, n_rd_more;
    logic            r_data_vld, n_data_vld;
    logic            r_pend_vld, n_pend_vld;
    logic [ID_W-1:0] r_pend_id, n_pend_id;
    logic            r_out_valid, n_out_valid;
    t_kind           r_out_kind, n_out_kind;
    logic [ID_W-1:0] r_out_id, n_out_id;
    logic            r_out_last, n_out_last;

    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr;
    logic [DW-1:0]   ram_wdata, ram_rdata;

    logic            out_free, req_ok, stall, issue, consume, scan_done, refuse;
    logic [IB-1:0]   ivl, rd_period, rd_elapsed, elap_inc;
    logic            expire;
    logic [31:0]     lim, add_id_w, cur_id_w;
    logic [CW-1:0]   cnt_m1;

    ptt_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_TIMERS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    assign out_free    = !r_out_valid || o_res.ready;
    assign i_req.ready = (r_state == S_IDLE) && out_free;
    assign req_ok      = i_req.valid && i_req.ready;

    assign ivl        = IB'(i_req.interval);
    assign lim        = (32'(r_max) > MAX_TIMERS) ? MAX_TIMERS : 32'(r_max);
    assign refuse     = (ivl == '0) || (32'(r_count) >= lim);
    assign add_id_w   = 32'(r_count) + 32'd1;
    assign cnt_m1     = r_count - 1'b1;

    // Table word holds the period in the upper half and the elapsed count below.
    assign rd_period  = ram_rdata[DW-1:IB];
    assign rd_elapsed = ram_rdata[IB-1:0];
    assign elap_inc   = rd_elapsed + 1'b1;
    assign expire     = elap_inc >= rd_period;
    assign cur_id_w   = 32'(r_cur_idx) + 32'd1;

    // A second expiry cannot displace the held one until the result slot frees.
    // The RAM read is not re-enabled while stalled, so its output holds.
    assign stall     = r_data_vld && expire && r_pend_vld && !out_free;
    assign issue     = (r_state == S_SCAN) && r_rd_more && !stall;
    assign consume   = (r_state == S_SCAN) && r_data_vld && !stall;
    assign scan_done = (r_state == S_SCAN) && !r_rd_more && !r_data_vld;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_ok && (i_req.cmd == CMD_TICK) && (r_count != '0)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_state = r_pend_vld ? S_FLUSH : S_IDLE;
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_cur_idx   = r_cur_idx;
        n_rd_more   = r_rd_more;
        n_data_vld  = r_data_vld;
        n_pend_vld  = r_pend_vld;
        n_pend_id   = r_pend_id;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_kind  = r_out_kind;
        n_out_id    = r_out_id;
        n_out_last  = r_out_last;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = r_cur_idx;
        ram_wdata   = {rd_period, (expire ? {IB{1'b0}} : elap_inc)};

        unique case (r_state)
            S_IDLE: begin
                if (req_ok) begin
                    if (i_req.cmd == CMD_ADD) begin
                        n_out_valid = 1'b1;
                        n_out_last  = 1'b1;
                        if (refuse) begin
                            n_out_kind = KIND_REFUSED;
                            n_out_id   = '0;
                        end else begin
                            ram_we     = 1'b1;
                            ram_waddr  = r_count[AW-1:0];
                            ram_wdata  = {ivl, {IB{1'b0}}};
                            n_count    = r_count + 1'b1;
                            n_out_kind = KIND_ADDED;
                            n_out_id   = add_id_w[ID_W-1:0];
                        end
                    end else begin
                        n_rd_idx   = cnt_m1[AW-1:0];
                        n_rd_more  = (r_count != '0);
                        n_data_vld = 1'b0;
                        n_pend_vld = 1'b0;
                    end
                end
            end
            S_SCAN: begin
                n_data_vld = issue || stall;
                if (issue) begin
                    ram_re    = 1'b1;
                    n_cur_idx = r_rd_idx;
                    n_rd_idx  = r_rd_idx - 1'b1;
                    n_rd_more = (r_rd_idx != '0);
                end
                if (consume) begin
                    ram_we = 1'b1;
                    if (expire) begin
                        if (r_pend_vld) begin
                            n_out_valid = 1'b1;
                            n_out_kind  = KIND_EXPIRED;
                            n_out_id    = r_pend_id;
                            n_out_last  = 1'b0;
                        end
                        n_pend_vld = 1'b1;
                        n_pend_id  = cur_id_w[ID_W-1:0];
                    end
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_EXPIRED;
                    n_out_id    = r_pend_id;
                    n_out_last  = 1'b1;
                    n_pend_vld  = 1'b0;
                end
            end
            default: begin
                n_pend_vld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max       <= MAX_TIMERS_RST;
            r_count     <= '0;
            r_rd_more   <= 1'b0;
            r_data_vld  <= 1'b0;
            r_pend_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_more   <= n_rd_more;
            r_data_vld  <= n_data_vld;
            r_pend_vld  <= n_pend_vld;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_cur_idx  <= n_cur_idx;
        r_pend_id  <= n_pend_id;
        r_out_kind <= n_out_kind;
        r_out_id   <= n_out_id;
        r_out_last <= n_out_last;
    end

    assign o_res.valid  = r_out_valid;
    assign o_res.kind   = r_out_kind;
    assign o_res.tmr_id = r_out_id;
    assign o_res.last   = r_out_last;

endmodule
